// ===== sv/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority timeslice task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int CMD_W     = 2;
    localparam int PRIO_W    = 8;
    localparam int SLICE_W   = 16;
    localparam int TASK_ID_W = 4;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;

    // one task table entry
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [SLICE_W-1:0] slice;
        logic [SLICE_W-1:0] rem;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_DECIDE,
        ST_SCAN2,
        ST_PICK2,
        ST_RESP
    } t_state;

endpackage

// ===== sv/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_if
// Valid/ready channels of the task scheduler: command in, result out.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [pts_pkg::CMD_W-1:0]    cmd;
    logic [pts_pkg::PRIO_W-1:0]   task_priority;
    logic [pts_pkg::SLICE_W-1:0]  task_slice;

    modport source (output valid, cmd, task_priority, task_slice, input ready);
    modport sink   (input valid, cmd, task_priority, task_slice, output ready);
endinterface

interface pts_res_if;
    logic                           valid;
    logic                           ready;
    logic [pts_pkg::TASK_ID_W-1:0]  running_task;
    logic                           running_valid;
    logic                           switched;
    logic                           accepted;
    logic [pts_pkg::TASK_ID_W-1:0]  created_index;
    logic                           yield_request;

    modport source (output valid, running_task, running_valid, switched, accepted,
                    created_index, yield_request, input ready);
    modport sink   (input valid, running_task, running_valid, switched, accepted,
                    created_index, yield_request, output ready);
endinterface

// ===== sv/priority_timeslice_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_timeslice_task_scheduler
// Preemptive priority round-robin scheduler over a table of TASK_SLOTS tasks.
//
// i_cmd carries one command per transaction: tick, create task or exit the
// running task. o_res returns exactly one result transaction per command.
// Only one command is in flight; i_cmd.ready is high while the sequencer idles,
// also while a finished result still waits on o_res.
// Create and exit: the result is registered in the result state once o_res is free.
// Tick: one pass (SCAN1) over the created entries of the task table at one
// entry per cycle through the single read port of the table memory, then
// DECIDE; when DECIDE takes no task and the running slice is spent, a second
// pass (SCAN2) for a lower-priority task and PICK2 follow.
// The running task's entry lives in working registers and is written back to
// the table on a switch. A stalled o_res holds its result; the next result is
// loaded once it has been taken. Reset empties the table (alive bits cleared)
// and leaves no task running; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_timeslice_task_scheduler #(
    parameter int TASK_SLOTS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pts_cmd_if.sink    i_cmd,
    pts_res_if.source  o_res
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

    pts_pkg::t_state r_state, n_state;

    pts_pkg::t_entry r_mem [TASK_SLOTS];
    pts_pkg::t_entry r_rd;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    pts_pkg::t_entry             mem_wdata;
    logic                        mem_re;

    logic [TASK_SLOTS-1:0]       r_alive;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_idx;
    logic [IDX_W-1:0]            r_chk_idx;
    logic                        r_chk_v;

    logic                        r_cur_valid;
    logic [IDX_W-1:0]            r_cur;
    logic [pts_pkg::PRIO_W-1:0]  r_cur_prio;
    logic [pts_pkg::SLICE_W-1:0] r_cur_slice;
    logic [pts_pkg::SLICE_W-1:0] r_cur_rem;

    logic                        r_found;
    logic [IDX_W-1:0]            r_best_idx;
    logic [pts_pkg::PRIO_W-1:0]  r_best_prio;
    logic [pts_pkg::SLICE_W-1:0] r_best_slice;

    logic                        r_sw;
    logic                        r_acc;
    logic                        r_yield;
    logic [IDX_W-1:0]            r_cidx;

    logic                             r_out_valid;
    logic [pts_pkg::TASK_ID_W-1:0]    r_o_task;
    logic                             r_o_rv;
    logic                             r_o_sw;
    logic                             r_o_acc;
    logic [pts_pkg::TASK_ID_W-1:0]    r_o_cidx;
    logic                             r_o_yield;

    logic cmd_fire;
    logic scan_done;
    logic cand;
    logic better;
    logic take1;
    logic out_free;

    assign cmd_fire  = i_cmd.valid && i_cmd.ready;
    assign scan_done = (r_idx == r_count);
    assign out_free  = !r_out_valid || o_res.ready;
    assign take1     = r_found && (!r_cur_valid || r_best_prio <= r_cur_prio);

    // candidate test on the entry read in the previous cycle
    always_comb begin
        if (r_state == pts_pkg::ST_SCAN1) begin
            cand = r_chk_v && r_alive[r_chk_idx] && (r_rd.rem != '0)
                   && !(r_cur_valid && (r_chk_idx == r_cur));
        end else begin
            cand = r_chk_v && r_alive[r_chk_idx] && (r_rd.prio > r_cur_prio);
        end
        better = cand && (!r_found || (r_rd.prio < r_best_prio));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pts_pkg::ST_IDLE: begin
                if (cmd_fire) begin
                    n_state = (i_cmd.cmd == pts_pkg::CMD_TICK) ? pts_pkg::ST_SCAN1
                                                                : pts_pkg::ST_RESP;
                end
            end
            pts_pkg::ST_SCAN1: begin
                if (scan_done) n_state = pts_pkg::ST_DECIDE;
            end
            pts_pkg::ST_DECIDE: begin
                if (take1) begin
                    n_state = pts_pkg::ST_RESP;
                end else if (r_cur_valid && (r_cur_rem == '0)) begin
                    n_state = pts_pkg::ST_SCAN2;
                end else begin
                    n_state = pts_pkg::ST_RESP;
                end
            end
            pts_pkg::ST_SCAN2: begin
                if (scan_done) n_state = pts_pkg::ST_PICK2;
            end
            pts_pkg::ST_PICK2: begin
                n_state = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_RESP: begin
                if (out_free) n_state = pts_pkg::ST_IDLE;
            end
            default: n_state = pts_pkg::ST_IDLE;
        endcase
    end

    // outputs and table port control
    always_comb begin
        i_cmd.ready = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_cur;
        mem_wdata   = '{prio: r_cur_prio, slice: r_cur_slice, rem: r_cur_rem};
        unique case (r_state)
            pts_pkg::ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (cmd_fire && (i_cmd.cmd == pts_pkg::CMD_CREATE)
                    && (r_count < SLOTS_CNT)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[IDX_W-1:0];
                    mem_wdata = '{prio: i_cmd.task_priority, slice: i_cmd.task_slice,
                                  rem: i_cmd.task_slice};
                end
            end
            pts_pkg::ST_SCAN1, pts_pkg::ST_SCAN2: begin
                mem_re = !scan_done;
            end
            pts_pkg::ST_DECIDE: begin
                mem_we = take1 && r_cur_valid;
            end
            pts_pkg::ST_PICK2: begin
                mem_we = r_found;
            end
            pts_pkg::ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.running_task  = r_o_task;
    assign o_res.running_valid = r_o_rv;
    assign o_res.switched      = r_o_sw;
    assign o_res.accepted      = r_o_acc;
    assign o_res.created_index = r_o_cidx;
    assign o_res.yield_request = r_o_yield;

    // task table
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pts_pkg::ST_IDLE;
            r_alive     <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if ((r_state == pts_pkg::ST_RESP) && out_free) begin
                r_out_valid <= 1'b1;
                r_o_task    <= r_cur_valid ? pts_pkg::TASK_ID_W'(r_cur) : '0;
                r_o_rv      <= r_cur_valid;
                r_o_sw      <= r_sw;
                r_o_acc     <= r_acc;
                r_o_cidx    <= pts_pkg::TASK_ID_W'(r_cidx);
                r_o_yield   <= r_yield;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                pts_pkg::ST_IDLE: begin
                    if (cmd_fire) begin
                        r_sw    <= 1'b0;
                        r_acc   <= 1'b0;
                        r_yield <= 1'b0;
                        r_cidx  <= '0;
                        r_idx   <= '0;
                        r_chk_v <= 1'b0;
                        r_found <= 1'b0;
                        case (i_cmd.cmd)
                            pts_pkg::CMD_TICK: begin
                                if (r_cur_valid && (r_cur_rem != '0)) begin
                                    r_cur_rem <= r_cur_rem - 1'b1;
                                end
                            end
                            pts_pkg::CMD_CREATE: begin
                                if (r_count < SLOTS_CNT) begin
                                    r_alive[r_count[IDX_W-1:0]] <= 1'b1;
                                    r_count <= r_count + 1'b1;
                                    r_acc   <= 1'b1;
                                    r_cidx  <= r_count[IDX_W-1:0];
                                    r_yield <= !r_cur_valid
                                               || (i_cmd.task_priority < r_cur_prio);
                                end
                            end
                            pts_pkg::CMD_EXIT: begin
                                if (r_cur_valid) begin
                                    r_alive[r_cur] <= 1'b0;
                                    r_cur_valid    <= 1'b0;
                                    r_cur          <= '0;
                                    r_yield        <= 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                pts_pkg::ST_SCAN1, pts_pkg::ST_SCAN2: begin
                    if (!scan_done) r_idx <= r_idx + 1'b1;
                    r_chk_idx <= r_idx[IDX_W-1:0];
                    r_chk_v   <= !scan_done;
                    if (better) begin
                        r_found      <= 1'b1;
                        r_best_idx   <= r_chk_idx;
                        r_best_prio  <= r_rd.prio;
                        r_best_slice <= r_rd.slice;
                    end
                end
                pts_pkg::ST_DECIDE: begin
                    r_idx   <= '0;
                    r_chk_v <= 1'b0;
                    r_found <= 1'b0;
                    if (take1) begin
                        r_cur       <= r_best_idx;
                        r_cur_valid <= 1'b1;
                        r_cur_prio  <= r_best_prio;
                        r_cur_slice <= r_best_slice;
                        r_cur_rem   <= r_best_slice;
                        r_sw        <= 1'b1;
                    end else if (r_cur_valid && (r_cur_rem == '0)) begin
                        r_cur_rem <= r_cur_slice;
                    end
                end
                pts_pkg::ST_PICK2: begin
                    if (r_found) begin
                        r_cur       <= r_best_idx;
                        r_cur_prio  <= r_best_prio;
                        r_cur_slice <= r_best_slice;
                        r_cur_rem   <= r_best_slice;
                        r_sw        <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_running_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_alive[r_cur])
        else $error("running task is not alive");

    a_running_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (CNT_W'(r_cur) < r_count))
        else $error("running task beyond created tasks");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_CNT)
        else $error("task count beyond capacity");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.running_valid) |-> (o_res.running_task == '0))
        else $error("running index set with no running task");

endmodule

// ===== tb/priority_timeslice_task_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_timeslice_task_scheduler_tb
// Self-checking bench for the task scheduler. A driver plays a queue of
// commands into i_cmd in bursts with random gaps. It predicts each
// transaction's result from a local copy of the task table. A monitor
// checks every o_res transaction in order while the result side stalls on
// its own pattern, with long holds that back the block up.
// ----------------------------------------------------------------------------
module priority_timeslice_task_scheduler_tb;

    localparam int SLOTS      = 10;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;
    localparam int ID_W       = pts_pkg::TASK_ID_W;

    typedef struct packed {
        logic [pts_pkg::CMD_W-1:0]   cmd;
        logic [pts_pkg::PRIO_W-1:0]  prio;
        logic [pts_pkg::SLICE_W-1:0] slice;
    } t_sched_cmd;

    typedef struct packed {
        logic [ID_W-1:0] running_task;
        logic            running_valid;
        logic            switched;
        logic            accepted;
        logic [ID_W-1:0] created_index;
        logic            yield_request;
    } t_sched_result;

    typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE} t_rx_mode;

    logic clk;
    logic rst_n;

    pts_cmd_if cmd_ch();
    pts_res_if res_ch();

    priority_timeslice_task_scheduler #(
        .TASK_SLOTS(SLOTS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // shadow task table
    logic [pts_pkg::PRIO_W-1:0]  prio_tbl  [SLOTS];
    bit                          alive_tbl [SLOTS];
    logic [pts_pkg::SLICE_W-1:0] slice_tbl [SLOTS];
    logic [pts_pkg::SLICE_W-1:0] rem_tbl   [SLOTS];
    int                          tasks_made;
    int                          run_idx;
    bit                          run_on;

    t_sched_cmd    cmd_backlog[$];
    t_sched_result result_backlog[$];
    t_sched_cmd    next_cmd;
    t_sched_result want_res;
    t_sched_result got_res;

    int total_cmds;
    int sent_cmds;
    int checked_results;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int n_ticks, n_creates, n_exits, n_switches, n_rejected;

    int       hold_left;
    int       taken_results;
    int       next_hold_at;
    int       mode_left;
    t_rx_mode rx_mode;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit ranks_first(int a, int b);
        if (prio_tbl[a] != prio_tbl[b])
            return prio_tbl[a] < prio_tbl[b];
        return a < b;
    endfunction

    function automatic void start_task(int idx);
        rem_tbl[idx] = slice_tbl[idx];
        run_idx      = idx;
        run_on       = 1'b1;
    endfunction

    function automatic bit scheduler_tick();
        bit found;
        int best;
        found = 1'b0;
        best  = 0;
        if (run_on && rem_tbl[run_idx] != 0)
            rem_tbl[run_idx] = rem_tbl[run_idx] - 1'b1;
        for (int i = 0; i < tasks_made; i++) begin
            if (!alive_tbl[i] || rem_tbl[i] == 0)
                continue;
            if (run_on && i == run_idx)
                continue;
            if (!found || ranks_first(i, best)) begin
                best  = i;
                found = 1'b1;
            end
        end
        if (found && (!run_on || prio_tbl[best] <= prio_tbl[run_idx])) begin
            start_task(best);
            return 1'b1;
        end
        if (run_on && rem_tbl[run_idx] == 0) begin
            rem_tbl[run_idx] = slice_tbl[run_idx];
            found = 1'b0;
            for (int i = 0; i < tasks_made; i++) begin
                if (!alive_tbl[i] || prio_tbl[i] <= prio_tbl[run_idx])
                    continue;
                if (!found || ranks_first(i, best)) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                start_task(best);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_sched_result schedule_step(t_sched_cmd c);
        t_sched_result r;
        int            idx;
        r = '0;
        case (c.cmd)
            pts_pkg::CMD_TICK: begin
                r.switched = scheduler_tick();
            end
            pts_pkg::CMD_CREATE: begin
                if (tasks_made < SLOTS) begin
                    idx            = tasks_made;
                    prio_tbl[idx]  = c.prio;
                    slice_tbl[idx] = c.slice;
                    rem_tbl[idx]   = c.slice;
                    alive_tbl[idx] = 1'b1;
                    tasks_made++;
                    r.accepted      = 1'b1;
                    r.created_index = idx[ID_W-1:0];
                    r.yield_request = !run_on || c.prio < prio_tbl[run_idx];
                end
            end
            pts_pkg::CMD_EXIT: begin
                if (run_on) begin
                    alive_tbl[run_idx] = 1'b0;
                    slice_tbl[run_idx] = '0;
                    rem_tbl[run_idx]   = '0;
                    run_on             = 1'b0;
                    run_idx            = 0;
                    r.yield_request    = 1'b1;
                end
            end
            default: ;
        endcase
        r.running_task  = run_on ? run_idx[ID_W-1:0] : '0;
        r.running_valid = run_on;
        return r;
    endfunction

    task automatic log_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, int want, logic [ID_W-1:0] got);
        if ($isunknown(got) || want != int'(got))
            log_failure($sformatf("result %0d %s: expected %0d, got %0h",
                                  checked_results, name, want, got));
    endtask

    function automatic void add_cmd(logic [pts_pkg::CMD_W-1:0] c, int prio, int slice);
        t_sched_cmd item;
        item.cmd   = c;
        item.prio  = prio[pts_pkg::PRIO_W-1:0];
        item.slice = slice[pts_pkg::SLICE_W-1:0];
        cmd_backlog.push_back(item);
    endfunction

    // driver: predict on each accepted transaction, then offer the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_ch.valid         <= 1'b0;
            cmd_ch.cmd           <= pts_pkg::CMD_TICK;
            cmd_ch.task_priority <= '0;
            cmd_ch.task_slice    <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                next_cmd = '{cmd_ch.cmd, cmd_ch.task_priority, cmd_ch.task_slice};
                want_res = schedule_step(next_cmd);
                result_backlog.push_back(want_res);
                sent_cmds++;
                case (next_cmd.cmd)
                    pts_pkg::CMD_TICK: begin
                        n_ticks++;
                        n_switches += int'(want_res.switched);
                    end
                    pts_pkg::CMD_CREATE: begin
                        n_creates++;
                        n_rejected += int'(!want_res.accepted);
                    end
                    pts_pkg::CMD_EXIT: n_exits++;
                    default: ;
                endcase
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd_ch.cmd           <= next_cmd.cmd;
                    cmd_ch.task_priority <= next_cmd.prio;
                    cmd_ch.task_slice    <= next_cmd.slice;
                    cmd_ch.valid         <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result side: stall pattern plus occasional long holds
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready  <= 1'b0;
            hold_left     = 0;
            taken_results = 0;
            next_hold_at  = 400;
            mode_left     = 0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                taken_results++;
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (taken_results >= next_hold_at) begin
                hold_left    = HOLD_LEN;
                next_hold_at = next_hold_at + 800;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_FREE: res_ch.ready <= 1'b1;
                    RX_HALF: res_ch.ready <= 1'($urandom_range(0, 1));
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got_res = '{res_ch.running_task, res_ch.running_valid, res_ch.switched,
                        res_ch.accepted, res_ch.created_index, res_ch.yield_request};
            if (result_backlog.size() == 0) begin
                log_failure($sformatf("result %0d arrived with no command pending",
                                      checked_results));
            end else begin
                want_res = result_backlog.pop_front();
                check_field("running_task", int'(want_res.running_task),
                            got_res.running_task);
                check_field("running_valid", int'(want_res.running_valid),
                            ID_W'(got_res.running_valid));
                check_field("switched", int'(want_res.switched),
                            ID_W'(got_res.switched));
                check_field("accepted", int'(want_res.accepted),
                            ID_W'(got_res.accepted));
                check_field("created_index", int'(want_res.created_index),
                            got_res.created_index);
                check_field("yield_request", int'(want_res.yield_request),
                            ID_W'(got_res.yield_request));
            end
            checked_results++;
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int creates_planned;
        int pick;
        int prio;
        int slice;

        rst_n = 1'b0;

        // directed: empty table, slice and priority extremes, rotation, exits
        add_cmd(pts_pkg::CMD_EXIT, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_CREATE, 255, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_CREATE, 200, 1);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_CREATE, 0, 65535);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_CREATE, 0, 3);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_EXIT, 0, 0);
        add_cmd(pts_pkg::CMD_EXIT, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_CREATE, 128, 2);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        add_cmd(pts_pkg::CMD_TICK, 0, 0);
        creates_planned = 5;

        // random: mostly ticks, remaining slots filled early, rare exits
        for (int n = 0; n < 1630; n++) begin
            pick = $urandom_range(0, 999);
            prio = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                0:       slice = 0;
                1:       slice = 65535;
                2, 3:    slice = $urandom_range(0, 65535);
                default: slice = $urandom_range(1, 4);
            endcase
            if (creates_planned < SLOTS && pick < 40) begin
                add_cmd(pts_pkg::CMD_CREATE, prio, slice);
                creates_planned++;
            end else if (pick < 45) begin
                add_cmd(pts_pkg::CMD_EXIT, $urandom_range(0, 255), $urandom_range(0, 65535));
            end else if (pick < 60) begin
                add_cmd(pts_pkg::CMD_CREATE, $urandom_range(0, 255),
                        $urandom_range(0, 65535));
                creates_planned++;
            end else begin
                add_cmd(pts_pkg::CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 65535));
            end
        end
        total_cmds = cmd_backlog.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!(sent_cmds == total_cmds && result_backlog.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge clk);

        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d of %0d commands sent, %0d results outstanding",
                     sent_cmds, total_cmds, result_backlog.size());
            $display("[FAIL] regression broken");
        end else begin
            repeat (40) @(posedge clk);
            $display("Ran %0d commands: %0d ticks with %0d task switches, %0d creates",
                     sent_cmds, n_ticks, n_switches, n_creates);
            $display("(%0d refused on a full table), %0d exits; %0d results, %0d mismatches",
                     n_rejected, n_exits, checked_results, mismatches);
            if (mismatches == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
